>>> rtl/core/pctd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_pkg
// Shared types, constants and helpers of the percent-escape decoder.
// ----------------------------------------------------------------------------
package pctd_pkg;

	localparam logic [7:0] PCT_CHAR   = 8'h25;
	localparam logic [7:0] SPACE_CHAR = 8'h20;

	// escape phase codes
	localparam logic [1:0] PH_PLAIN = 2'd0;
	localparam logic [1:0] PH_PCT   = 2'd1;
	localparam logic [1:0] PH_HEX   = 2'd2;

	localparam int unsigned MAX_RES = 3;

	// results of one input byte, oldest in data[0]
	typedef struct packed {
		logic [1:0]            cnt;
		logic                  fin;
		logic [2:0][7:0]       data;
	} pctd_res_t;

	// one queued result
	typedef struct packed {
		logic [7:0] data;
		logic       run_end;
		logic       string_end;
	} pctd_entry_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] nib;
	} pctd_hex_t;

	function automatic pctd_hex_t pctd_hex(input logic [7:0] c);
		pctd_hex_t h;
		h.ok  = 1'b1;
		h.nib = 4'd0;
		if (c >= 8'h41 && c <= 8'h46) begin
			h.nib = 4'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.nib = 4'(c - 8'h57);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			h.nib = c[3:0];
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

	// append one byte, drop it once the list is full
	function automatic pctd_res_t pctd_append(input pctd_res_t r, input logic [7:0] b);
		pctd_res_t o;
		o = r;
		if (r.cnt != 2'd3) begin
			o.data[r.cnt] = b;
			o.cnt = r.cnt + 2'd1;
		end
		return o;
	endfunction

endpackage

>>> rtl/core/pctd_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_decode
// Escape state register and the single-pass decode of one input byte into
// up to three result bytes.
// ----------------------------------------------------------------------------
module pctd_decode import pctd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      in_byte,
	input  logic            in_final,
	output pctd_res_t       res
);

	logic [1:0] phase_q;
	logic [7:0] held_q;
	logic [1:0] phase_d;
	logic [7:0] held_d;
	logic       do_plain;
	pctd_hex_t  hb;
	pctd_hex_t  hh;
	logic [7:0] dec;
	pctd_res_t  r;

	always_comb begin
		hb       = pctd_hex(in_byte);
		hh       = pctd_hex(held_q);
		dec      = {hh.nib, hb.nib};
		r        = '0;
		r.fin    = in_final;
		phase_d  = PH_PLAIN;
		held_d   = held_q;
		do_plain = 1'b0;
		unique case (phase_q)
			PH_PCT: begin
				if (hb.ok) begin
					held_d  = in_byte;
					phase_d = PH_HEX;
				end else begin
					r        = pctd_append(r, PCT_CHAR);
					do_plain = 1'b1;
				end
			end
			PH_HEX: begin
				if (hb.ok) begin
					r = pctd_append(r, (dec > SPACE_CHAR) ? dec : SPACE_CHAR);
				end else begin
					r        = pctd_append(r, PCT_CHAR);
					r        = pctd_append(r, held_q);
					do_plain = 1'b1;
				end
			end
			default: begin
				do_plain = 1'b1;
			end
		endcase
		if (do_plain) begin
			if (in_byte == PCT_CHAR) begin
				phase_d = PH_PCT;
			end else begin
				r = pctd_append(r, in_byte);
			end
		end
		// end of string: flush a pending escape as literal text
		if (in_final) begin
			if (phase_d == PH_PCT) begin
				r = pctd_append(r, PCT_CHAR);
			end else if (phase_d == PH_HEX) begin
				r = pctd_append(r, PCT_CHAR);
				r = pctd_append(r, held_d);
			end
			phase_d = PH_PLAIN;
		end
	end

	assign res = r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLAIN;
			held_q  <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
		end
	end

	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != 2'd3)
		else $error("escape phase left its legal codes");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_final |=> phase_q == PH_PLAIN)
		else $error("escape still pending after end of string");

	a_final_emits: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_final |-> res.cnt != 2'd0)
		else $error("end of string produced no result");

endmodule

>>> rtl/core/pctd_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_outq
// Four-entry result queue: takes up to three bytes per transfer, drains
// one byte per unstalled cycle, stalls input while under three slots free.
// ----------------------------------------------------------------------------
module pctd_outq import pctd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  pctd_res_t       res,
	output logic            full,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [7:0]      out_byte,
	output logic            run_end,
	output logic            string_end
);

	pctd_entry_t mem_q [4];
	logic [1:0]  wr_ptr_q;
	logic [1:0]  rd_ptr_q;
	logic [2:0]  count_q;
	logic [1:0]  push_n;
	logic        pop;
	pctd_entry_t rd_entry;

	assign push_n    = push ? res.cnt : 2'd0;
	assign pop       = out_valid && !out_stall;
	assign full      = count_q > 3'd1;
	assign out_valid = count_q != 3'd0;
	assign rd_entry  = mem_q[rd_ptr_q];
	assign out_byte  = rd_entry.data;
	assign run_end   = rd_entry.run_end;
	assign string_end = rd_entry.string_end;

	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (push && 2'(i) < res.cnt) begin
				mem_q[wr_ptr_q + 2'(i)].data       <= res.data[2'(i)];
				mem_q[wr_ptr_q + 2'(i)].run_end    <= (2'(i) == res.cnt - 2'd1);
				mem_q[wr_ptr_q + 2'(i)].string_end <= (2'(i) == res.cnt - 2'd1) && res.fin;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + push_n;
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + {1'b0, push_n} - {2'b0, pop};
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'd4)
		else $error("result queue overflow");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push_n != 2'd0 |-> count_q <= 3'd1)
		else $error("results written without three free slots");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		count_q == 3'd1 && pop && push_n == 2'd0 |=> !out_valid)
		else $error("queue did not empty after last transfer");

endmodule

>>> rtl/core/percent_escape_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_escape_decoder
// Streaming %HH decoder for query strings.
//
// Input channel: in_byte/in_final with in_valid, in_stall. in_final marks the
// last byte of a string and flushes a pending escape as literal text.
// Output channel: out_byte, run_end, string_end with out_valid, out_stall.
// run_end marks the last byte caused by one input transfer, string_end the
// last byte of a string. An input byte causes zero to three output bytes.
// Results of a byte enter the result queue at its transfer and are offered
// behind any entries still queued. Throughput: one input byte per cycle while
// each causes at most one result and the output does not stall. The input
// stalls while the four-entry result queue has fewer than three free slots.
// Reset clears the escape state and empties the queue. When the receiver
// stalls, the head result holds and the queue fills, then the input stalls.
// ----------------------------------------------------------------------------
module percent_escape_decoder import pctd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_final,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        run_end,
	output logic        string_end
);

	logic      accept;
	logic      full;
	pctd_res_t res;

	assign in_stall = full;
	assign accept   = in_valid && !full;

	pctd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.in_byte  (in_byte),
		.in_final (in_final),
		.res      (res)
	);

	pctd_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.res        (res),
		.full       (full),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_end    (run_end),
		.string_end (string_end)
	);

endmodule
